### hw/rtl/gbbp_pkg.sv
// ----------------------------------------------------------------------------
// gbbp_pkg
// Shared types and constants for the gshare predictor with branch target
// buffer: command codes, address widths, counter limits and the BTB entry.
// ----------------------------------------------------------------------------
package gbbp_pkg;

    // Address and counter widths
    localparam int PC_W   = 64;
    localparam int CTR_W  = 2;
    localparam int IDX_LSB = 2;

    // Command codes carried in the request cmd field
    localparam logic [0:0] CMD_PREDICT = 1'b0;
    localparam logic [0:0] CMD_UPDATE  = 1'b1;

    // Saturating counter limits
    localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;
    localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 2'd2;

    // Sequential fetch step
    localparam logic [PC_W-1:0] PC_STEP = 64'd4;

    // One BTB entry, always written whole
    typedef struct packed {
        logic            valid;
        logic            cond;
        logic [PC_W-1:0] tag;
        logic [PC_W-1:0] target;
    } btb_line_t;

    localparam int BTB_ENTRY_W = $bits(btb_line_t);

endpackage

### hw/rtl/gbbp_req_if.sv
// ----------------------------------------------------------------------------
// gbbp_req_if
// Request channel: predict or update command with branch information.
// ----------------------------------------------------------------------------
interface gbbp_req_if;

    logic                        valid;
    logic                        ready;
    logic [0:0]                  cmd;
    logic [gbbp_pkg::PC_W-1:0]   inst_pc;
    logic                        is_conditional;
    logic [gbbp_pkg::PC_W-1:0]   branch_target;
    logic                        was_taken;

    modport source (
        output valid,
        output cmd,
        output inst_pc,
        output is_conditional,
        output branch_target,
        output was_taken,
        input  ready
    );

    modport sink (
        input  valid,
        input  cmd,
        input  inst_pc,
        input  is_conditional,
        input  branch_target,
        input  was_taken,
        output ready
    );

endinterface

### hw/rtl/gbbp_rsp_if.sv
// ----------------------------------------------------------------------------
// gbbp_rsp_if
// Response channel: prediction for one predict command.
// ----------------------------------------------------------------------------
interface gbbp_rsp_if;

    logic                        valid;
    logic                        ready;
    logic                        predicted_taken;
    logic [gbbp_pkg::PC_W-1:0]   next_pc;

    modport source (
        output valid,
        output predicted_taken,
        output next_pc,
        input  ready
    );

    modport sink (
        input  valid,
        input  predicted_taken,
        input  next_pc,
        output ready
    );

endinterface

### hw/rtl/gbbp_ram.sv
// ----------------------------------------------------------------------------
// gbbp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbbp_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 2
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/gshare_btb_branch_predictor.sv
// ----------------------------------------------------------------------------
// gshare_btb_branch_predictor
// Gshare direction predictor with a direct-mapped branch target buffer.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer. A predict command (cmd = 0) looks
//   up the counter table (history XOR pc[PHT_BITS+1:2]) and the BTB
//   (pc[BTB_BITS+1:2]) and returns one transfer on rsp: predicted_taken and
//   next_pc (BTB target when taken, else inst_pc + 4). An update command
//   (cmd = 1) writes the BTB entry and, for a conditional branch, trains the
//   counter and shifts the outcome into the global history; it returns
//   nothing.
//   Pipeline: the tables are read and the lookup stage loads at the request
//   transfer; the result register loads when the prediction leaves the lookup
//   stage and drives rsp.valid. Throughput: one command per cycle outside the
//   clearing pass and rsp stalls, set by the single read port of each table;
//   back-to-back commands to the same entry are forwarded from the stage that writes.
//   Reset: a clearing pass writes every table entry while req.ready is low.
//   Stall: while rsp.ready is low the result register holds; one more
//   prediction may wait in the lookup stage, then req.ready drops for every
//   command. An update in the lookup stage never waits on rsp.
// ----------------------------------------------------------------------------
module gshare_btb_branch_predictor #(
    parameter int PHT_BITS = 8,
    parameter int BTB_BITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    gbbp_req_if.sink   req,
    gbbp_rsp_if.source rsp
);

    localparam int CLR_BITS = (PHT_BITS > BTB_BITS) ? PHT_BITS : BTB_BITS;
    localparam int PC_W     = gbbp_pkg::PC_W;
    localparam int CTR_W    = gbbp_pkg::CTR_W;
    localparam int ENTRY_W  = gbbp_pkg::BTB_ENTRY_W;

    // Clearing pass
    logic                clr_active_reg;
    logic [CLR_BITS-1:0] clr_idx_reg;

    // Global history
    logic [PHT_BITS-1:0] history_reg;
    logic [PHT_BITS-1:0] history_next;

    // Lookup stage
    logic                s1_valid_reg;
    logic [0:0]          s1_cmd_reg;
    logic [PC_W-1:0]     s1_pc_reg;
    logic                s1_cond_reg;
    logic [PC_W-1:0]     s1_target_reg;
    logic                s1_taken_reg;
    logic [PHT_BITS-1:0] s1_pht_idx_reg;
    logic [BTB_BITS-1:0] s1_btb_idx_reg;
    logic                fwd_ctr_hit_reg;
    logic [CTR_W-1:0]    fwd_ctr_reg;
    logic                fwd_btb_hit_reg;
    gbbp_pkg::btb_line_t fwd_btb_reg;

    // Result register
    logic                out_valid_reg;
    logic                out_taken_reg;
    logic [PC_W-1:0]     out_pc_reg;

    logic                req_xfer;
    logic                s1_upd;
    logic                s1_hist_upd;
    logic                s1_pred;
    logic                s1_advance;
    logic                out_load;

    logic [PHT_BITS-1:0] in_pht_idx;
    logic [BTB_BITS-1:0] in_btb_idx;
    logic                in_fwd_ctr_hit;
    logic                in_fwd_btb_hit;

    logic [CTR_W-1:0]    ctr_rd;
    logic [ENTRY_W-1:0]  btb_rd;
    logic [CTR_W-1:0]    ctr_cur;
    logic [CTR_W-1:0]    ctr_new;
    gbbp_pkg::btb_line_t btb_cur;
    gbbp_pkg::btb_line_t btb_new;

    logic                pred_hit;
    logic                pred_taken;
    logic [PC_W-1:0]     pred_pc;

    logic                pht_we;
    logic [PHT_BITS-1:0] pht_waddr;
    logic [CTR_W-1:0]    pht_wdata;
    logic                btb_we;
    logic [BTB_BITS-1:0] btb_waddr;
    gbbp_pkg::btb_line_t btb_wdata;

    // Handshake and stage control
    assign s1_upd      = s1_valid_reg && (s1_cmd_reg == gbbp_pkg::CMD_UPDATE);
    assign s1_pred     = s1_valid_reg && (s1_cmd_reg == gbbp_pkg::CMD_PREDICT);
    assign s1_hist_upd = s1_upd && s1_cond_reg;
    assign s1_advance  = !s1_pred || !out_valid_reg || rsp.ready;
    assign out_load    = s1_pred && s1_advance;
    assign req.ready   = !clr_active_reg && s1_advance;
    assign req_xfer    = req.valid && req.ready;

    // Resolve current table contents, with forwarding from the previous write
    assign ctr_cur = fwd_ctr_hit_reg ? fwd_ctr_reg : ctr_rd;
    assign btb_cur = fwd_btb_hit_reg ? fwd_btb_reg : gbbp_pkg::btb_line_t'(btb_rd);

    // Saturate counter up or down
    always_comb
    begin
        ctr_new = ctr_cur;
        if (s1_taken_reg)
        begin
            if (ctr_cur != gbbp_pkg::CTR_MAX)
            begin
                ctr_new = ctr_cur + CTR_W'(1);
            end
        end
        else
        begin
            if (ctr_cur != gbbp_pkg::CTR_MIN)
            begin
                ctr_new = ctr_cur - CTR_W'(1);
            end
        end
    end

    assign btb_new.valid  = 1'b1;
    assign btb_new.cond   = s1_cond_reg;
    assign btb_new.tag    = s1_pc_reg;
    assign btb_new.target = s1_target_reg;

    // Shift outcome into history on a conditional update
    assign history_next = s1_hist_upd ? {history_reg[PHT_BITS-2:0], s1_taken_reg}
                                      : history_reg;

    // Table indices for the incoming command, using the history it will see
    assign in_pht_idx = req.inst_pc[gbbp_pkg::IDX_LSB +: PHT_BITS] ^ history_next;
    assign in_btb_idx = req.inst_pc[gbbp_pkg::IDX_LSB +: BTB_BITS];

    assign in_fwd_ctr_hit = s1_hist_upd && (s1_pht_idx_reg == in_pht_idx);
    assign in_fwd_btb_hit = s1_upd && (s1_btb_idx_reg == in_btb_idx);

    // Prediction
    assign pred_hit   = btb_cur.valid && (btb_cur.tag == s1_pc_reg);
    assign pred_taken = pred_hit &&
                        (!btb_cur.cond || (ctr_cur >= gbbp_pkg::CTR_TAKEN_MIN));
    assign pred_pc    = pred_taken ? btb_cur.target : (s1_pc_reg + gbbp_pkg::PC_STEP);

    // Table write ports: clearing pass, else training from the lookup stage
    always_comb
    begin
        if (clr_active_reg)
        begin
            pht_we    = 1'b1;
            pht_waddr = clr_idx_reg[PHT_BITS-1:0];
            pht_wdata = gbbp_pkg::CTR_MIN;
            btb_we    = 1'b1;
            btb_waddr = clr_idx_reg[BTB_BITS-1:0];
            btb_wdata = '0;
        end
        else
        begin
            pht_we    = s1_hist_upd;
            pht_waddr = s1_pht_idx_reg;
            pht_wdata = ctr_new;
            btb_we    = s1_upd;
            btb_waddr = s1_btb_idx_reg;
            btb_wdata = btb_new;
        end
    end

    gbbp_ram #(
        .ADDR_W (PHT_BITS),
        .DATA_W (CTR_W)
    ) u_pht (
        .clk   (clk),
        .we    (pht_we),
        .waddr (pht_waddr),
        .wdata (pht_wdata),
        .re    (req_xfer),
        .raddr (in_pht_idx),
        .rdata (ctr_rd)
    );

    gbbp_ram #(
        .ADDR_W (BTB_BITS),
        .DATA_W (ENTRY_W)
    ) u_btb (
        .clk   (clk),
        .we    (btb_we),
        .waddr (btb_waddr),
        .wdata (btb_wdata),
        .re    (req_xfer),
        .raddr (in_btb_idx),
        .rdata (btb_rd)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            history_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + CLR_BITS'(1);
                if (clr_idx_reg == {CLR_BITS{1'b1}})
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            history_reg <= history_next;
            if (req_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Lookup stage payload: load on request transfer
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            s1_cmd_reg      <= req.cmd;
            s1_pc_reg       <= req.inst_pc;
            s1_cond_reg     <= req.is_conditional;
            s1_target_reg   <= req.branch_target;
            s1_taken_reg    <= req.was_taken;
            s1_pht_idx_reg  <= in_pht_idx;
            s1_btb_idx_reg  <= in_btb_idx;
            fwd_ctr_hit_reg <= in_fwd_ctr_hit;
            fwd_ctr_reg     <= ctr_new;
            fwd_btb_hit_reg <= in_fwd_btb_hit;
            fwd_btb_reg     <= btb_new;
        end
    end

    // Result payload: load when a prediction leaves the lookup stage
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_taken_reg <= pred_taken;
            out_pc_reg    <= pred_pc;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.predicted_taken = out_taken_reg;
    assign rsp.next_pc         = out_pc_reg;

`ifndef ASSERT_OFF
    // No command is taken while the tables are being cleared
    a_no_accept_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !req.ready
    ) else $error("request accepted during clearing pass");

    // A new result only comes from a prediction in the lookup stage
    a_result_from_predict: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_pred)
    ) else $error("result produced without a predict command");

    // History moves only on a conditional update
    a_history_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s1_hist_upd |=> $stable(history_reg)
    ) else $error("history changed without a conditional update");

    // A taken outcome never lowers the counter
    a_ctr_up: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_hist_upd && s1_taken_reg) |-> (ctr_new >= ctr_cur)
    ) else $error("counter decreased on a taken outcome");
`endif

endmodule
